// ----- rtl/jhtd_pkg.sv -----
// Package for the canonical Huffman table decoder: command codes, sizes,
// and the command/status structs shared by the controller and datapath.
// No dependencies.
`default_nettype none

package jhtd_pkg;

    // Table geometry
    localparam int NUM_LENGTHS  = 16;
    localparam int LEN_IDX_W    = 4;
    localparam int MAX_CODE_LEN = 16;
    localparam int MAX_SYMBOLS  = 256;
    localparam int STORE_DEPTH  = 256;
    localparam int STORE_AW     = 8;
    localparam int POS_W        = 9;
    localparam int NODE_W       = 9;
    localparam int NODE_SAT     = 511;
    // Canonical code accumulator during node build; sixteen steps of
    // (c + 255) * 2 stay below 2^25.
    localparam int ACC_W        = 26;

    // Item commands
    typedef logic [1:0] cmd_code_t;
    localparam cmd_code_t CMD_START = 2'd0;
    localparam cmd_code_t CMD_BYTE  = 2'd1;
    localparam cmd_code_t CMD_BIT   = 2'd2;
    localparam cmd_code_t CMD_NONE  = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic                 clear;
        logic                 load;
        logic                 decode;
        logic                 first_step;
        logic                 node_step;
        logic [LEN_IDX_W-1:0] step;
    } jhtd_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic load_done;
    } jhtd_stat_t;

endpackage

`default_nettype wire

// ----- rtl/jhtd_ctrl.sv -----
// Controller for the canonical Huffman table decoder: accepts transactions
// and sequences the two-pass node build after the last table byte.
// Depends on jhtd_pkg.
`default_nettype none

module jhtd_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire jhtd_pkg::cmd_code_t cmd,
    input  wire jhtd_pkg::jhtd_stat_t stat,
    output      jhtd_pkg::jhtd_ctl_t  ctl,
    output      logic                busy
);
    import jhtd_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FIRST = 2'd1;
    localparam logic [1:0] S_NODES = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [LEN_IDX_W-1:0] step_reg, step_next;
    logic                 accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // Next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        ctl            = '0;
        ctl.step       = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                step_next = '0;
                if (accept)
                begin
                    case (cmd)
                        CMD_START: ctl.clear  = 1'b1;
                        CMD_BYTE:
                        begin
                            ctl.load = 1'b1;
                            if (stat.load_done)
                                state_next = S_FIRST;
                        end
                        CMD_BIT:   ctl.decode = 1'b1;
                        default:   ;
                    endcase
                end
            end
            S_FIRST:
            begin
                ctl.first_step = 1'b1;
                step_next      = step_reg + 1'b1;
                if (step_reg == LEN_IDX_W'(NUM_LENGTHS - 1))
                    state_next = S_NODES;
            end
            S_NODES:
            begin
                ctl.node_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == LEN_IDX_W'(NUM_LENGTHS - 1))
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
                step_next  = '0;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/jhtd_datapath.sv -----
// Datapath for the canonical Huffman table decoder: table storage, symbol
// store, canonical node build, bit-serial decode and result registers.
// Depends on jhtd_pkg.
`default_nettype none

module jhtd_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire jhtd_pkg::jhtd_ctl_t  ctl,
    input  wire logic [7:0]           table_byte,
    input  wire logic                 code_bit,
    output      jhtd_pkg::jhtd_stat_t stat,
    output      logic                 done,
    output      logic [7:0]           symbol,
    output      logic [4:0]           code_length,
    output      logic                 error
);
    import jhtd_pkg::*;

    // Table state
    logic [7:0]        counts_reg [NUM_LENGTHS];
    logic [NODE_W-1:0] nodes_reg  [NUM_LENGTHS];
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  total_reg;
    logic              ready_reg;

    // Decode state
    logic [15:0]       accum_reg;
    logic [4:0]        depth_reg;
    logic [15:0]       first_reg;
    logic [POS_W-1:0]  symidx_reg;

    // Node build scratch
    logic [ACC_W-1:0]  c_reg;
    logic [ACC_W-1:0]  last_reg;
    logic [ACC_W-1:0]  firsts_reg [NUM_LENGTHS];

    // Symbol store and result registers
    logic [7:0]        store_mem [STORE_DEPTH];
    logic [7:0]        store_q_reg;
    logic              done_reg;
    logic              hit_reg;
    logic [4:0]        len_reg;
    logic              err_reg;

    // Load path signals
    logic              in_counts;
    logic [POS_W:0]    total_sum;
    logic [POS_W-1:0]  total_new;
    logic              load_done;
    logic              store_we;
    logic [STORE_AW-1:0] store_waddr;

    // Decode signals
    logic [LEN_IDX_W-1:0] di;
    logic [LEN_IDX_W-1:0] cnt_addr;
    logic [7:0]        cnt;
    logic [15:0]       accum_new;
    logic [15:0]       off;
    logic [4:0]        len;
    logic              hit;
    logic              descend;
    logic              store_re;
    logic [STORE_AW-1:0] store_raddr;

    // Build signals
    logic              has_deepest;
    logic [LEN_IDX_W-1:0] deepest;
    logic [ACC_W-1:0]  build_sum;
    logic [LEN_IDX_W-1:0] shamt;
    logic [ACC_W:0]    top1;
    logic [ACC_W:0]    first_ext;
    logic [ACC_W:0]    node_diff;
    logic [NODE_W-1:0] node_val;

    // Table byte accounting
    always_comb
    begin
        in_counts   = (pos_reg < POS_W'(NUM_LENGTHS));
        total_sum   = {1'b0, total_reg} + {2'b00, table_byte};
        total_new   = (total_sum > (POS_W+1)'(MAX_SYMBOLS)) ? POS_W'(MAX_SYMBOLS)
                                                           : total_sum[POS_W-1:0];
        if (ready_reg)
            load_done = 1'b0;
        else if (in_counts)
            load_done = (pos_reg == POS_W'(NUM_LENGTHS - 1)) && (total_new == '0);
        else
            load_done = ((pos_reg - POS_W'(NUM_LENGTHS - 1)) >= total_reg);
        store_we    = ctl.load && !ready_reg && !in_counts;
        store_waddr = pos_reg[STORE_AW-1:0] - STORE_AW'(NUM_LENGTHS);
    end

    assign stat.load_done = load_done;

    // Decode step: one code bit against the current depth
    always_comb
    begin
        di          = depth_reg[LEN_IDX_W-1:0];
        cnt_addr    = ctl.first_step ? ctl.step : di;
        cnt         = counts_reg[cnt_addr];
        accum_new   = {accum_reg[14:0], code_bit};
        off         = accum_new - first_reg;
        len         = depth_reg + 5'd1;
        hit         = (off < {8'd0, cnt});
        descend     = (off < {7'd0, nodes_reg[di]}) && (len < 5'(MAX_CODE_LEN));
        store_re    = ctl.decode && ready_reg && hit;
        store_raddr = symidx_reg[STORE_AW-1:0] + off[STORE_AW-1:0];
    end

    // Deepest used length
    always_comb
    begin
        has_deepest = 1'b0;
        deepest     = '0;
        for (int i = 0; i < NUM_LENGTHS; i++)
        begin
            if ((counts_reg[i] != 8'd0) && (i < MAX_CODE_LEN))
            begin
                has_deepest = 1'b1;
                deepest     = LEN_IDX_W'(i);
            end
        end
    end

    // Node count for one depth: (last >> (deepest - d)) + 1 - first, saturated
    always_comb
    begin
        build_sum = c_reg + {{(ACC_W-8){1'b0}}, cnt};
        shamt     = deepest - ctl.step;
        top1      = {1'b0, last_reg >> shamt} + (ACC_W+1)'(1);
        first_ext = {1'b0, firsts_reg[ctl.step]};
        node_diff = top1 - first_ext;
        if (!has_deepest || (ctl.step > deepest))
            node_val = '0;
        else if ((top1 < first_ext) || (node_diff > (ACC_W+1)'(NODE_SAT)))
            node_val = NODE_W'(NODE_SAT);
        else
            node_val = node_diff[NODE_W-1:0];
    end

    // Control and table state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LENGTHS; i++)
            begin
                counts_reg[i] <= '0;
                nodes_reg[i]  <= '0;
            end
            pos_reg    <= '0;
            total_reg  <= '0;
            ready_reg  <= 1'b0;
            accum_reg  <= '0;
            depth_reg  <= '0;
            first_reg  <= '0;
            symidx_reg <= '0;
            done_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            len_reg    <= '0;
            err_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.clear)
            begin
                for (int i = 0; i < NUM_LENGTHS; i++)
                begin
                    counts_reg[i] <= '0;
                    nodes_reg[i]  <= '0;
                end
                pos_reg    <= '0;
                total_reg  <= '0;
                ready_reg  <= 1'b0;
                accum_reg  <= '0;
                depth_reg  <= '0;
                first_reg  <= '0;
                symidx_reg <= '0;
            end

            // Table bytes
            if (ctl.load && !ready_reg)
            begin
                if (in_counts)
                begin
                    counts_reg[pos_reg[LEN_IDX_W-1:0]] <= table_byte;
                    total_reg <= total_new;
                end
                pos_reg <= pos_reg + 1'b1;
                if (load_done)
                    ready_reg <= 1'b1;
            end

            // Node build, second pass
            if (ctl.node_step)
                nodes_reg[ctl.step] <= node_val;

            // Code bits
            if (ctl.decode)
            begin
                done_reg <= 1'b1;
                if (!ready_reg)
                begin
                    hit_reg <= 1'b0;
                    len_reg <= '0;
                    err_reg <= 1'b1;
                end
                else if (hit)
                begin
                    hit_reg    <= 1'b1;
                    len_reg    <= len;
                    err_reg    <= 1'b0;
                    accum_reg  <= '0;
                    depth_reg  <= '0;
                    first_reg  <= '0;
                    symidx_reg <= '0;
                end
                else if (descend)
                begin
                    done_reg   <= 1'b0;
                    accum_reg  <= accum_new;
                    depth_reg  <= len;
                    first_reg  <= (first_reg + {8'd0, cnt}) << 1;
                    symidx_reg <= symidx_reg + {1'b0, cnt};
                end
                else
                begin
                    hit_reg    <= 1'b0;
                    len_reg    <= len;
                    err_reg    <= 1'b1;
                    accum_reg  <= '0;
                    depth_reg  <= '0;
                    first_reg  <= '0;
                    symidx_reg <= '0;
                end
            end
        end
    end

    // Node build, first pass: first code of each depth and last code
    always_ff @(posedge clk)
    begin
        if (ctl.load && load_done)
            c_reg <= '0;
        if (ctl.first_step)
        begin
            firsts_reg[ctl.step] <= c_reg;
            c_reg                <= build_sum << 1;
            if (ctl.step == deepest)
                last_reg <= build_sum - ACC_W'(1);
        end
    end

    // Symbol store
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[store_waddr] <= table_byte;
        if (store_re)
            store_q_reg <= store_mem[store_raddr];
    end

    assign done        = done_reg;
    assign symbol      = hit_reg ? store_q_reg : 8'd0;
    assign code_length = len_reg;
    assign error       = err_reg;

endmodule

`default_nettype wire

// ----- rtl/jpeg_huffman_table_decoder_top.sv -----
// Canonical Huffman table decoder, top level: controller plus datapath.
// A transaction is accepted while busy is low. A code bit that ends a code or
// fails gives its result (done high for one cycle, the receiver cannot stall)
// on the cycle after acceptance, one bit per cycle while busy is low. The last
// table byte starts a node build (two passes over the 16 lengths), busy high.
// Reset clears the table: no table is loaded and code bits report an error.
`default_nettype none

module jpeg_huffman_table_decoder_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output      logic       busy,
    input  wire logic [1:0] cmd,
    input  wire logic [7:0] table_byte,
    input  wire logic       code_bit,
    output      logic       done,
    output      logic [7:0] symbol,
    output      logic [4:0] code_length,
    output      logic       error
);
    import jhtd_pkg::*;

    jhtd_ctl_t  ctl;
    jhtd_stat_t stat;

    // Transaction sequencing
    jhtd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    // Table storage and decode
    jhtd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .table_byte  (table_byte),
        .code_bit    (code_bit),
        .stat        (stat),
        .done        (done),
        .symbol      (symbol),
        .code_length (code_length),
        .error       (error)
    );

endmodule

`default_nettype wire
